@@ hdl/bdth_pkg.sv @@
// ----------------------------------------------------------------------------
// bdth_pkg
// Shared types and constants for the button debounce / tap / hold block.
// ----------------------------------------------------------------------------
package bdth_pkg;

    // Field widths
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int EVENT_W   = 2;

    // Stream word widths (fields packed from bit 0, padded to whole bytes)
    localparam int IN_FIELDS_W  = 1 + TIME_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W   = ((EVENT_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS     = 1'b1;

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_MS_RESET = 16'd30;
    localparam logic [CFG_W-1:0] HOLD_MS_RESET     = 16'd800;

    // Line levels (active low button)
    localparam logic LEVEL_PRESSED  = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE       = 2'd0,
        EV_TAP        = 2'd1,
        EV_HOLD_START = 2'd2,
        EV_HOLD_END   = 2'd3
    } event_t;

endpackage

@@ hdl/button_debounce_tap_hold.sv @@
// ----------------------------------------------------------------------------
// button_debounce_tap_hold
// Debounces an active-low button sample stream and reports tap, hold start
// and hold end events, one event word per sample word.
// ----------------------------------------------------------------------------
//
//  Channel   | Direction | Payload
//  ----------+-----------+-----------------------------------------------------
//  s_axis    | in        | tdata[0] raw_level, tdata[32:1] now_ms, rest zero
//  m_axis    | out       | tdata[1:0] event_code, rest zero
//  cfg       | in        | cfg_we / cfg_index / cfg_wdata, 0 debounce, 1 hold
//
//  Flow: a sample word is captured in the input register, evaluated by
//  compare/subtract logic and lands in the output register; one word can be
//  taken every cycle while the output is not stalled.
//  Stalls: the input register drains when the output one is empty or taken;
//  s_axis_tready drops only when both are full and the output is not taken.
//  Reset: control flags and debounce/press state go to their idle values,
//  config registers to 30 ms debounce and 800 ms hold.
// ----------------------------------------------------------------------------
module button_debounce_tap_hold
(
    input  logic                              clk,
    input  logic                              rst_n,

    // Sample stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bdth_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // raw_level, now_ms

    // Event stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bdth_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // event_code

    // Configuration writes
    input  logic                              cfg_we,
    input  logic [bdth_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bdth_pkg::CFG_W-1:0]        cfg_wdata
);
    import bdth_pkg::*;

    // Config registers
    logic [CFG_W-1:0]  debounce_ms_reg;
    logic [CFG_W-1:0]  hold_ms_reg;

    // Input stage
    logic              in_valid_reg;
    logic              in_level_reg;
    logic [TIME_W-1:0] in_now_reg;

    // Output stage
    logic              out_valid_reg;
    event_t            out_code_reg;

    // Debounce / press state
    logic              last_level_reg,    last_level_next;
    logic [TIME_W-1:0] window_start_reg,  window_start_next;
    logic              is_pressed_reg,    is_pressed_next;
    logic [TIME_W-1:0] press_start_reg,   press_start_next;
    logic              hold_reported_reg, hold_reported_next;
    event_t            code_next;

    logic              out_free;
    logic              advance;
    logic [TIME_W-1:0] window_elapsed;
    logic [TIME_W-1:0] press_elapsed;
    logic              window_done;
    logic              hold_due;

    // Handshake: input register moves on whenever the output slot frees up
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-EVENT_W){1'b0}}, out_code_reg};

    // Wrapping elapsed times
    assign window_elapsed = in_now_reg - window_start_reg;
    assign press_elapsed  = in_now_reg - press_start_reg;
    assign window_done    = window_elapsed >= {{(TIME_W-CFG_W){1'b0}}, debounce_ms_reg};
    assign hold_due       = press_elapsed  >= {{(TIME_W-CFG_W){1'b0}}, hold_ms_reg};

    // Step of the debounce and tap/hold logic
    always_comb
    begin
        last_level_next    = last_level_reg;
        window_start_next  = window_start_reg;
        is_pressed_next    = is_pressed_reg;
        press_start_next   = press_start_reg;
        hold_reported_next = hold_reported_reg;
        code_next          = EV_NONE;

        if (in_level_reg != last_level_reg)
        begin
            // any level change restarts the window
            last_level_next   = in_level_reg;
            window_start_next = in_now_reg;
        end
        else if (window_done)
        begin
            if (in_level_reg == LEVEL_PRESSED && !is_pressed_reg)
            begin
                // press begins; no hold check this step
                is_pressed_next    = 1'b1;
                press_start_next   = in_now_reg;
                hold_reported_next = 1'b0;
            end
            else if (in_level_reg == LEVEL_RELEASED && is_pressed_reg)
            begin
                is_pressed_next = 1'b0;
                code_next       = hold_reported_reg ? EV_HOLD_END : EV_TAP;
            end
            else if (is_pressed_reg && !hold_reported_reg && hold_due)
            begin
                hold_reported_next = 1'b1;
                code_next          = EV_HOLD_START;
            end
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            last_level_reg    <= LEVEL_RELEASED;
            window_start_reg  <= '0;
            is_pressed_reg    <= 1'b0;
            press_start_reg   <= '0;
            hold_reported_reg <= 1'b0;
            debounce_ms_reg   <= DEBOUNCE_MS_RESET;
            hold_ms_reg       <= HOLD_MS_RESET;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end

            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end

            if (advance)
            begin
                last_level_reg    <= last_level_next;
                window_start_reg  <= window_start_next;
                is_pressed_reg    <= is_pressed_next;
                press_start_reg   <= press_start_next;
                hold_reported_reg <= hold_reported_next;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DEBOUNCE_MS: debounce_ms_reg <= cfg_wdata;
                    REG_HOLD_MS:     hold_ms_reg     <= cfg_wdata;
                    default:         ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_level_reg <= s_axis_tdata[0];
            in_now_reg   <= s_axis_tdata[TIME_W:1];
        end

        if (advance)
        begin
            out_code_reg <= code_next;
        end
    end

endmodule
